[design/diff_drive_wheel_speed_assert.svh]
// ----------------------------------------------------------------------------
// Differential-drive wheel speed: assertion macros
// Shared concurrent assertion forms used by the wheel speed back end.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_WHEEL_SPEED_ASSERT_SVH
`define DIFF_DRIVE_WHEEL_SPEED_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DDS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/dds_pkg.sv]
// ----------------------------------------------------------------------------
// Differential-drive wheel speed: package
// Item types, configuration layout, pipeline record and constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dds_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;
   localparam int unsigned ALPHA_STEPS     = 16;
   localparam int unsigned RATIO_STEPS     = 24;

   localparam logic [20:0] RAD_PER_RPM_Q24 = 21'd1756906;
   localparam logic [16:0] ALPHA_ONE       = 17'd256;
   localparam logic [16:0] ALPHA_MAX       = 17'd65280;
   localparam logic [24:0] RATIO_ONE       = 25'h1000000;
   localparam logic [63:0] ROUND_HALF      = 64'h0000_0080_0000_0000;

   typedef enum logic [7:0] {
      CSR_LINEAR_GAIN      = 8'd0,
      CSR_ANGULAR_GAIN     = 8'd1,
      CSR_TOP_LINEAR_SPEED = 8'd2,
      CSR_MOTOR_RPM_LIMIT  = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] linear_speed;
      logic signed [15:0] turn_rate;
   } req_item_type;

   typedef struct packed {
      logic signed [23:0] left_wheel_rate;
      logic signed [23:0] right_wheel_rate;
      logic               limited;
      logic               divisor_fault;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  index;
      logic [15:0] data;
   } csr_item_type;

   typedef struct packed {
      logic [15:0] linear_gain;
      logic [15:0] angular_gain;
      logic [14:0] top_linear_speed;
      logic [15:0] motor_rpm_limit;
   } config_type;

   typedef struct packed {
      logic            zero_cmd;
      logic            ang_zero;
      logic [15:0]     lin_mag;
      logic [15:0]     ang_mag;
      logic [1:0][31:0] v_mag;
      logic [1:0]      v_neg;
   } front_item_type;

   typedef struct packed {
      logic               zero_cmd;
      logic               ang_zero;
      logic [15:0]        lin_mag;
      logic [15:0]        ang_mag;
      logic [1:0][31:0]   v_mag;
      logic [1:0]         v_neg;
      logic               alpha_ovf;
      logic [15:0]        arem;
      logic [15:0]        anum;
      logic [15:0]        aquo;
      logic [16:0]        alpha;
      logic signed [34:0] prod_t;
      logic signed [35:0] sum_s;
      logic signed [51:0] mreach;
      logic               fault;
      logic               limited;
      logic [1:0]         wz;
      logic [1:0]         wsat;
      logic [1:0][50:0]   wrem;
      logic [1:0][23:0]   wquo;
      logic [1:0][40:0]   wp;
      logic [1:0][41:0]   wlo;
      logic [1:0][40:0]   whi;
   } work_type;

endpackage

[design/dds_if.sv]
// ----------------------------------------------------------------------------
// Differential-drive wheel speed: channel interfaces
// Valid/ready channels for commands, wheel results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dds_req_if;
   import dds_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dds_rsp_if;
   import dds_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dds_csr_if;
   import dds_pkg::*;
   logic         valid;
   logic         ready;
   csr_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[design/dds_front.sv]
// ----------------------------------------------------------------------------
// Differential-drive wheel speed: front end
// Accepts commands, forms the wheel sums and classifies each command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_front (
   input  logic                   clock,
   input  logic                   reset,
   dds_req_if.sink                req,
   input  dds_pkg::config_type    cfg,
   output dds_pkg::front_item_type push_item,
   output logic                   push_valid,
   input  logic                   push_ready
);
   import dds_pkg::*;

   logic               adv;
   logic               p1_valid_ff, p1_valid_in;
   logic signed [15:0] lin_ff, lin_in, ang_ff, ang_in;
   logic signed [32:0] plin_ff, plin_in, pang_ff, pang_in;
   logic               p2_valid_ff, p2_valid_in;
   front_item_type     p2_ff, p2_in;
   logic signed [33:0] vl, vr;

   always_comb begin
      adv         = !p2_valid_ff || push_ready;
      req.ready   = adv;
      p1_valid_in = req.valid;
      lin_in      = req.payload.linear_speed;
      ang_in      = req.payload.turn_rate;
      plin_in     = $signed({1'b0, cfg.linear_gain}) * req.payload.linear_speed;
      pang_in     = $signed({1'b0, cfg.angular_gain}) * req.payload.turn_rate;

      vl = 34'(plin_ff) - 34'(pang_ff);
      vr = 34'(plin_ff) + 34'(pang_ff);
      p2_valid_in      = p1_valid_ff;
      p2_in.zero_cmd   = (lin_ff == 16'sd0) && (ang_ff == 16'sd0);
      p2_in.ang_zero   = (ang_ff == 16'sd0);
      p2_in.lin_mag    = lin_ff[15] ? 16'(-lin_ff) : 16'(lin_ff);
      p2_in.ang_mag    = ang_ff[15] ? 16'(-ang_ff) : 16'(ang_ff);
      p2_in.v_neg[0]   = vl[33];
      p2_in.v_neg[1]   = vr[33];
      p2_in.v_mag[0]   = vl[33] ? 32'(-vl) : vl[31:0];
      p2_in.v_mag[1]   = vr[33] ? 32'(-vr) : vr[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_ff  <= lin_in;
         ang_ff  <= ang_in;
         plin_ff <= plin_in;
         pang_ff <= pang_in;
         p2_ff   <= p2_in;
      end
   end

   assign push_valid = p2_valid_ff;
   assign push_item  = p2_ff;

endmodule

[design/dds_queue.sv]
// ----------------------------------------------------------------------------
// Differential-drive wheel speed: decoupling queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_queue #(
   parameter int unsigned DEPTH = dds_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dds_pkg::front_item_type push_item,
   input  logic                    push_valid,
   output logic                    push_ready,
   output dds_pkg::front_item_type pop_item,
   output logic                    pop_valid,
   input  logic                    pop_ready
);
   import dds_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   front_item_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   always_comb begin
      push_ready = (count_ff != CNT_W'(DEPTH));
      pop_valid  = (count_ff != '0);
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      pop_item = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/dds_back.sv]
// ----------------------------------------------------------------------------
// Differential-drive wheel speed: back end
// Pipelined speed ratio, reachable speed, wheel ratio division and scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "diff_drive_wheel_speed_assert.svh"

module dds_back (
   input  logic                    clock,
   input  logic                    reset,
   input  dds_pkg::front_item_type pop_item,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  dds_pkg::config_type     cfg,
   dds_rsp_if.source               rsp
);
   import dds_pkg::*;

   logic adv;

   logic     s0_valid_ff;
   work_type s0_ff, s0_in;

   logic [ALPHA_STEPS-1:0] a_valid_ff;
   work_type a_ff  [ALPHA_STEPS];
   work_type a_in  [ALPHA_STEPS];
   work_type a_src [ALPHA_STEPS];

   logic     m1_valid_ff, m2_valid_ff, m3_valid_ff, m4_valid_ff;
   work_type m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in, m4_ff, m4_in;

   logic [RATIO_STEPS-1:0] r_valid_ff;
   work_type r_ff  [RATIO_STEPS];
   work_type r_in  [RATIO_STEPS];
   work_type r_src [RATIO_STEPS];

   logic         f1_valid_ff, f2_valid_ff, out_valid_ff;
   work_type     f1_ff, f1_in, f2_ff, f2_in;
   rsp_item_type out_ff, out_in;

   assign adv       = !out_valid_ff || rsp.ready;
   assign pop_ready = adv;

   always_comb begin
      s0_in           = '0;
      s0_in.zero_cmd  = pop_item.zero_cmd;
      s0_in.ang_zero  = pop_item.ang_zero;
      s0_in.lin_mag   = pop_item.lin_mag;
      s0_in.ang_mag   = pop_item.ang_mag;
      s0_in.v_mag     = pop_item.v_mag;
      s0_in.v_neg     = pop_item.v_neg;
      s0_in.alpha_ovf = ({8'h00, pop_item.lin_mag[15:8]} >= pop_item.ang_mag);
      s0_in.arem      = {8'h00, pop_item.lin_mag[15:8]};
      s0_in.anum      = {pop_item.lin_mag[7:0], 8'h00};
   end

   for (genvar j = 0; j < ALPHA_STEPS; j++) begin : g_alpha
      if (j == 0) begin : g_first
         assign a_src[j] = s0_ff;
      end else begin : g_next
         assign a_src[j] = a_ff[j-1];
      end
      always_comb begin
         logic [16:0] t;
         t        = {a_src[j].arem, a_src[j].anum[15]};
         a_in[j]  = a_src[j];
         if (t >= {1'b0, a_src[j].ang_mag}) begin
            a_in[j].arem = 16'(t - {1'b0, a_src[j].ang_mag});
            a_in[j].aquo = {a_src[j].aquo[14:0], 1'b1};
         end else begin
            a_in[j].arem = t[15:0];
            a_in[j].aquo = {a_src[j].aquo[14:0], 1'b0};
         end
         a_in[j].anum = {a_src[j].anum[14:0], 1'b0};
      end
   end

   always_comb begin
      m1_in = a_ff[ALPHA_STEPS-1];
      if (m1_in.ang_zero) begin
         m1_in.alpha = ALPHA_ONE;
      end else if (m1_in.alpha_ovf || ({1'b0, m1_in.aquo} > ALPHA_MAX)) begin
         m1_in.alpha = ALPHA_MAX;
      end else begin
         m1_in.alpha = {1'b0, m1_in.aquo};
      end
      m1_in.prod_t = $signed({1'b0, m1_in.alpha}) *
                     ($signed({1'b0, cfg.linear_gain}) - $signed({1'b0, cfg.angular_gain}));

      m2_in       = m1_ff;
      m2_in.sum_s = $signed({12'h000, cfg.angular_gain, 8'h00}) + 36'(m1_ff.prod_t);

      m3_in        = m2_ff;
      m3_in.mreach = m2_ff.sum_s * $signed({1'b0, cfg.top_linear_speed});

      m4_in         = m3_ff;
      m4_in.fault   = !m3_ff.zero_cmd && (m3_ff.mreach[51] || (m3_ff.mreach == '0));
      m4_in.limited = 1'b0;
      for (int w = 0; w < 2; w++) begin
         m4_in.wz[w]   = (m3_ff.v_mag[w] == '0);
         m4_in.wsat[w] = m4_in.fault || ({19'h0, m3_ff.v_mag[w]} >= m3_ff.mreach[50:0]);
         if (!m4_in.wz[w] &&
             (m4_in.fault || ({19'h0, m3_ff.v_mag[w]} > m3_ff.mreach[50:0]))) begin
            m4_in.limited = 1'b1;
         end
         m4_in.wrem[w] = 51'(m3_ff.v_mag[w]);
         m4_in.wquo[w] = '0;
      end
   end

   for (genvar j = 0; j < RATIO_STEPS; j++) begin : g_ratio
      if (j == 0) begin : g_first
         assign r_src[j] = m4_ff;
      end else begin : g_next
         assign r_src[j] = r_ff[j-1];
      end
      always_comb begin
         logic [51:0] t;
         logic [51:0] mu;
         r_in[j] = r_src[j];
         mu      = {1'b0, r_src[j].mreach[50:0]};
         for (int w = 0; w < 2; w++) begin
            t = {r_src[j].wrem[w], 1'b0};
            if (t >= mu) begin
               r_in[j].wrem[w] = 51'(t - mu);
               r_in[j].wquo[w] = {r_src[j].wquo[w][22:0], 1'b1};
            end else begin
               r_in[j].wrem[w] = t[50:0];
               r_in[j].wquo[w] = {r_src[j].wquo[w][22:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      logic [24:0] f;
      logic [63:0] total;
      logic [23:0] mag;
      f1_in = r_ff[RATIO_STEPS-1];
      for (int w = 0; w < 2; w++) begin
         if (f1_in.wz[w]) begin
            f = '0;
         end else if (f1_in.wsat[w]) begin
            f = RATIO_ONE;
         end else begin
            f = {1'b0, f1_in.wquo[w]};
         end
         f1_in.wp[w] = f * cfg.motor_rpm_limit;
      end

      f2_in = f1_ff;
      for (int w = 0; w < 2; w++) begin
         f2_in.wlo[w] = f1_ff.wp[w][20:0] * RAD_PER_RPM_Q24;
         f2_in.whi[w] = f1_ff.wp[w][40:21] * RAD_PER_RPM_Q24;
      end

      total = (64'(f2_ff.whi[0]) << 21) + 64'(f2_ff.wlo[0]) + ROUND_HALF;
      mag   = total[63:40];
      out_in.left_wheel_rate = f2_ff.v_neg[0] ? $signed(24'(0 - mag)) : $signed(mag);
      total = (64'(f2_ff.whi[1]) << 21) + 64'(f2_ff.wlo[1]) + ROUND_HALF;
      mag   = total[63:40];
      out_in.right_wheel_rate = f2_ff.v_neg[1] ? $signed(24'(0 - mag)) : $signed(mag);
      out_in.limited       = f2_ff.limited;
      out_in.divisor_fault = f2_ff.fault;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         a_valid_ff   <= '0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         m4_valid_ff  <= 1'b0;
         r_valid_ff   <= '0;
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff  <= pop_valid;
         a_valid_ff   <= {a_valid_ff[ALPHA_STEPS-2:0], s0_valid_ff};
         m1_valid_ff  <= a_valid_ff[ALPHA_STEPS-1];
         m2_valid_ff  <= m1_valid_ff;
         m3_valid_ff  <= m2_valid_ff;
         m4_valid_ff  <= m3_valid_ff;
         r_valid_ff   <= {r_valid_ff[RATIO_STEPS-2:0], m4_valid_ff};
         f1_valid_ff  <= r_valid_ff[RATIO_STEPS-1];
         f2_valid_ff  <= f1_valid_ff;
         out_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff  <= s0_in;
         a_ff   <= a_in;
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         m3_ff  <= m3_in;
         m4_ff  <= m4_in;
         r_ff   <= r_in;
         f1_ff  <= f1_in;
         f2_ff  <= f2_in;
         out_ff <= out_in;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   `DDS_ASSERT_IMPLY(a_fault_sets_limited, clock, reset,
      out_valid_ff && out_ff.divisor_fault &&
      ((out_ff.left_wheel_rate != '0) || (out_ff.right_wheel_rate != '0)),
      out_ff.limited, "wheel driven under a divisor fault without the limited flag")
   `DDS_ASSERT_IMPLY(a_zero_cmd_clean, clock, reset,
      m4_valid_ff && m4_ff.zero_cmd, !m4_ff.fault && !m4_ff.limited && (m4_ff.wz == 2'b11),
      "zero command classified with a fault, a limit or a nonzero wheel")
   `DDS_ASSERT_NEXT(a_stall_holds, clock, reset,
      out_valid_ff && !rsp.ready, out_valid_ff && $stable(out_ff),
      "result register changed while stalled")

endmodule

[design/diff_drive_wheel_speed.sv]
// Throughput: one command per cycle while results are taken, set by the fully pipelined ratio and wheel dividers.
// A four-entry queue lets the front end keep accepting while results are held up.
// Reset is synchronous and active high; it empties the pipeline and queue and
// restores the register defaults (gains 1.0, top speed 1.0 m/s, 3000 rpm).
// ----------------------------------------------------------------------------
// Differential-drive wheel speed: top level
// Register file, front end, decoupling queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_wheel_speed #(
   parameter int unsigned QUEUE_DEPTH = dds_pkg::QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dds_req_if.sink   req,
   dds_rsp_if.source rsp,
   dds_csr_if.sink   csr
);
   import dds_pkg::*;

   config_type     cfg_ff, cfg_in;
   front_item_type push_item, pop_item;
   logic           push_valid, push_ready, pop_valid, pop_ready;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.payload.index)
            CSR_LINEAR_GAIN:      cfg_in.linear_gain      = csr.payload.data;
            CSR_ANGULAR_GAIN:     cfg_in.angular_gain     = csr.payload.data;
            CSR_TOP_LINEAR_SPEED: cfg_in.top_linear_speed = csr.payload.data[14:0];
            CSR_MOTOR_RPM_LIMIT:  cfg_in.motor_rpm_limit  = csr.payload.data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_gain      <= 16'd256;
         cfg_ff.angular_gain     <= 16'd256;
         cfg_ff.top_linear_speed <= 15'd4096;
         cfg_ff.motor_rpm_limit  <= 16'd3000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg_ff),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   dds_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   dds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_item  (pop_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .cfg       (cfg_ff),
      .rsp       (rsp)
   );

endmodule

[test/diff_drive_wheel_speed_tb.sv]
// ----------------------------------------------------------------------------
// Differential-drive wheel speed: testbench
// Sends velocity commands under several register settings and compares each
// wheel result with a cycle-free fixed-point prediction of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_wheel_speed_tb;
   import dds_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT = 500000;

   logic clock;
   logic reset;

   dds_req_if req_ch ();
   dds_rsp_if rsp_ch ();
   dds_csr_if csr_ch ();

   diff_drive_wheel_speed u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   req_item_type pending_cmds[$];
   rsp_item_type expected_rates[$];
   config_type   regs;
   int           errors = 0;
   int           sent = 0;
   int           checked = 0;
   int           faults_seen = 0;
   int           limits_seen = 0;
   int           cycles = 0;
   int           send_gap = 0;
   int           recv_stall = 0;
   int           hold_left = 0;
   int           hold_token = 0;
   int           hold_seen = 0;
   bit           quiet = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned mag(longint x);
      return (x < 0) ? longint'(-x) : longint'(x);
   endfunction

   function automatic rsp_item_type wheel_rates(req_item_type c, config_type g);
      longint           lin;
      longint           ang;
      longint           v[2];
      longint           reach;
      longint unsigned  alpha;
      longint unsigned  a;
      longint unsigned  f;
      longint unsigned  m;
      logic [23:0]      res[2];
      rsp_item_type     r;
      r = '0;
      lin = longint'($signed(c.linear_speed));
      ang = longint'($signed(c.turn_rate));
      if (lin == 0 && ang == 0) begin
         return r;
      end
      v[0] = longint'(g.linear_gain) * lin - longint'(g.angular_gain) * ang;
      v[1] = longint'(g.linear_gain) * lin + longint'(g.angular_gain) * ang;
      if (ang == 0) begin
         alpha = ALPHA_ONE;
      end else begin
         alpha = (mag(lin) << 8) / mag(ang);
         if (alpha > ALPHA_MAX) alpha = ALPHA_MAX;
      end
      reach = longint'(alpha) * longint'(g.linear_gain) * longint'(g.top_linear_speed)
            + (longint'(ALPHA_ONE) - longint'(alpha)) * longint'(g.angular_gain)
              * longint'(g.top_linear_speed);
      r.divisor_fault = (reach <= 0);
      for (int w = 0; w < 2; w++) begin
         a = mag(v[w]);
         if (a == 0) begin
            res[w] = '0;
         end else begin
            if (r.divisor_fault) begin
               f = RATIO_ONE;
               r.limited = 1'b1;
            end else if (a >= longint'(reach)) begin
               f = RATIO_ONE;
               if (a > longint'(reach)) r.limited = 1'b1;
            end else begin
               f = (a << 24) / longint'(reach);
            end
            m = (f * g.motor_rpm_limit * RAD_PER_RPM_Q24 + ROUND_HALF) >> 40;
            if (v[w] < 0) m = -m;
            res[w] = m[23:0];
         end
      end
      r.left_wheel_rate = res[0];
      r.right_wheel_rate = res[1];
      return r;
   endfunction

   task automatic report(string field, longint got, longint want);
      errors++;
      $display("mismatch on item %0d: %s got %0d, expected %0d", checked, field, got, want);
   endtask

   // Command driver: predicts each item as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rates.push_back(wheel_rates(req_ch.payload, regs));
            sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               req_ch.valid <= 1'b1;
               req_ch.payload <= pending_cmds.pop_front();
               if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 9);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result ready, with random stalls and the long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) recv_stall <= $urandom_range(1, 9);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rates.size() == 0) begin
            errors++;
            $display("result with no command outstanding");
         end else begin
            want = expected_rates.pop_front();
            if (rsp_ch.payload.left_wheel_rate !== want.left_wheel_rate)
               report("left_wheel_rate", rsp_ch.payload.left_wheel_rate,
                      want.left_wheel_rate);
            if (rsp_ch.payload.right_wheel_rate !== want.right_wheel_rate)
               report("right_wheel_rate", rsp_ch.payload.right_wheel_rate,
                      want.right_wheel_rate);
            if (rsp_ch.payload.limited !== want.limited)
               report("limited", rsp_ch.payload.limited, want.limited);
            if (rsp_ch.payload.divisor_fault !== want.divisor_fault)
               report("divisor_fault", rsp_ch.payload.divisor_fault, want.divisor_fault);
            faults_seen += want.divisor_fault;
            limits_seen += want.limited;
            checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("diff_drive_wheel_speed_tb: done, errors");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.payload <= '{index: idx, data: data};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_LINEAR_GAIN: regs.linear_gain = data;
         CSR_ANGULAR_GAIN: regs.angular_gain = data;
         CSR_TOP_LINEAR_SPEED: regs.top_linear_speed = data[14:0];
         default: regs.motor_rpm_limit = data;
      endcase
   endtask

   task automatic set_regs(logic [15:0] lg, logic [15:0] ag, logic [14:0] top,
                           logic [15:0] rpm);
      write_reg(CSR_LINEAR_GAIN, lg);
      write_reg(CSR_ANGULAR_GAIN, ag);
      write_reg(CSR_TOP_LINEAR_SPEED, {1'b0, top});
      write_reg(CSR_MOTOR_RPM_LIMIT, rpm);
   endtask

   task automatic drain();
      while (pending_cmds.size() > 0 || req_ch.valid || expected_rates.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void add_cmd(int lin, int ang);
      pending_cmds.push_back('{linear_speed: lin[15:0], turn_rate: ang[15:0]});
   endfunction

   function automatic void add_random(int n);
      int lin;
      int ang;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: begin lin = $urandom_range(0, 65535); ang = 0; end
            1: begin lin = 0; ang = $urandom_range(0, 65535); end
            2: begin lin = $urandom_range(0, 255) - 128; ang = $urandom_range(0, 255) - 128; end
            3: begin
               lin = $urandom_range(0, 1) ? 32767 : -32768;
               ang = $urandom_range(0, 1) ? 32767 : -32768;
            end
            default: begin lin = $urandom_range(0, 65535); ang = $urandom_range(0, 65535); end
         endcase
         add_cmd(lin, ang);
      end
   endfunction

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.payload = '0;
      regs = '{linear_gain: 16'd256, angular_gain: 16'd256, top_linear_speed: 15'd4096,
               motor_rpm_limit: 16'd3000};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Defaults after reset: directed corners.
      add_cmd(0, 0);
      add_cmd(4096, 0);
      add_cmd(0, 4096);
      add_cmd(32767, 32767);
      add_cmd(-32768, -32768);
      add_cmd(32767, -32768);
      add_cmd(-32768, 32767);
      add_cmd(4096, 4096);
      add_cmd(1, -1);
      add_cmd(-1, 0);
      add_cmd(32767, 1);
      add_cmd(1, 32767);
      add_random(150);
      drain();

      // The result side holds off while commands keep arriving.
      hold_token++;
      add_random(100);
      drain();

      set_regs(16'd0, 16'd0, 15'd0, 16'd0);
      add_cmd(4096, 4096);
      add_cmd(0, 1);
      add_random(60);
      drain();

      set_regs(16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF);
      add_cmd(32767, 0);
      add_cmd(-32768, 32767);
      add_random(150);
      drain();

      // No linear gain makes the reachable speed negative for fast commands.
      set_regs(16'd0, 16'd256, 15'd4096, 16'd3000);
      add_cmd(1000, 1);
      add_cmd(-1000, 1);
      add_cmd(0, 100);
      add_random(120);
      drain();

      // Wheel sum equal to the reachable speed sits at the limit unflagged.
      set_regs(16'd256, 16'd256, 15'd64, 16'd6000);
      add_cmd(16384, 0);
      add_cmd(-16384, 0);
      add_cmd(16385, 0);
      add_random(120);
      drain();

      for (int p = 0; p < 3; p++) begin
         set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  15'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)));
         add_random(110);
         drain();
      end

      set_regs(16'd256, 16'd512, 15'd2048, 16'd100);
      add_random(50);
      quiet = 1;
      add_random(80);
      drain();

      $display("%0d commands checked over 9 register settings, %0d limited, %0d faulted",
               checked, limits_seen, faults_seen);
      if (errors == 0 && expected_rates.size() == 0) begin
         $display("diff_drive_wheel_speed_tb: done, clean");
      end else begin
         $display("diff_drive_wheel_speed_tb: done, errors");
      end
      $finish;
   end

endmodule

[diff_drive_wheel_speed.f]
+incdir+design
design/dds_pkg.sv
design/dds_if.sv
design/dds_front.sv
design/dds_queue.sv
design/dds_back.sv
design/diff_drive_wheel_speed.sv
test/diff_drive_wheel_speed_tb.sv
